// ===== hw/rtl/stod_pkg.sv =====
// ---------------------------------------------------------------------------
// Scaled time-of-day clock package
// Shared constants for the clock datapath and its serial arithmetic units.
// ---------------------------------------------------------------------------
package stod_pkg;
  localparam int TICKS_PER_SECOND = 60;
  localparam int TW = 48;
  localparam int DW = 36;
  localparam int DAY_S = 86400;
  localparam int HOUR_S = 3600;
  localparam int MIN_S = 60;
  localparam int TICK_NUM = 1440 * 256;
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] REG_RMPD  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_PAUSE = 2'd2;
  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
endpackage

// ===== hw/rtl/stod_div.sv =====
// ---------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, 36-bit operands.
// ---------------------------------------------------------------------------
module stod_div import stod_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem, quo[DW-1]} - {1'b0, divisor};
  assign quotient = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= dividend;
        cnt <= 6'(DW);
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-2:0], quo[DW-1]};
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/scaled_time_of_day_clock.sv =====
// ---------------------------------------------------------------------------
// Scaled time-of-day clock
// Virtual clock with tick, set and read transactions, one result each.
// ---------------------------------------------------------------------------
// Each transaction returns one result with the time after it. All division
// runs through one shared 36-bit serial divider that yields one quotient bit
// per cycle, and splitting the whole seconds into days, hours, minutes and
// seconds takes three divisions. A read, a spare operation or a paused tick
// presents its result after that split, and an unpaused tick adds one
// division for the increment. A set runs the split, a multiply and an apply
// step for each target it applies, skips each unused target, and then runs
// the split once more for its result. A new transaction is accepted from
// the cycle after the result is loaded into the output register, so the next
// one runs while a result waits; the block stalls only when a finished result
// finds that register still full. Registers are meant to be written only
// while no transaction is in flight.
module scaled_time_of_day_clock import stod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], set_day[18:2], set_hour[24:19], set_minute[31:25],
  // set_second[38:32], zero fill
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // day_now[15:0], hour_now[20:16], minute_now[26:21], second_now[32:27],
  // total_seconds[64:33], zero fill
  output logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_NEXT  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  localparam logic [1:0] U_DAY  = 2'd0;
  localparam logic [1:0] U_HOUR = 2'd1;
  localparam logic [1:0] U_MIN  = 2'd2;

  logic [15:0]        rmpd;
  logic [15:0]        tscale;
  logic               paused;
  logic [TW-1:0]      game_time;
  logic [2:0]         state;
  logic [1:0]         phase;
  logic [1:0]         unit;
  logic [3:0]         pend;
  logic [16:0]        sday;
  logic [5:0]         shour;
  logic [6:0]         smin;
  logic [6:0]         ssec;
  logic [15:0]        dq;
  logic [4:0]         hq;
  logic [5:0]         mq;
  logic [5:0]         sq;
  logic signed [35:0] adj;
  logic [71:0]        obuf;
  logic               obuf_v;
  logic               div_busy;
  logic               dstart;
  logic               ddone;
  logic [DW-1:0]      ddiv;
  logic [DW-1:0]      ddvs;
  logic [DW-1:0]      dquo;
  logic [DW-1:0]      drem;
  logic [15:0]        rmpd_eff;
  logic [25:0]        tick_den;
  logic [DW-1:0]      tick_num;
  logic [TW:0]        tick_sum;
  logic [31:0]        secs;
  logic signed [17:0] step_tgt;
  logic signed [17:0] step_cur;
  logic signed [17:0] step_unit;
  logic signed [17:0] step_diff;
  logic signed [52:0] g_ext;
  logic signed [52:0] a_ext;
  logic signed [52:0] r_pos;
  logic signed [52:0] r_neg;
  logic signed [52:0] r_sel;
  logic               put;

  stod_div u_div (.clk, .rst, .start(dstart), .dividend(ddiv), .divisor(ddvs),
    .done(ddone), .quotient(dquo), .remainder(drem));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = obuf_v;
  assign m_tdata = obuf;
  assign secs = game_time[TW-1:16];

  assign rmpd_eff = (rmpd == 16'd0) ? 16'd1 : rmpd;
  assign tick_den = 26'(rmpd_eff) * 26'(TICKS_PER_SECOND);
  assign tick_num = DW'(tscale) * DW'(TICK_NUM);
  assign tick_sum = {1'b0, game_time} + (TW+1)'(dquo);
  assign dstart = ((state == S_TICK) || (state == S_DEC)) && !div_busy;
  assign put = (state == S_PUT) && (!obuf_v || m_tready);

  always_comb begin
    if (state == S_TICK) begin
      ddiv = tick_num;
      ddvs = DW'(tick_den);
    end else begin
      case (phase)
        2'd0: begin
          ddiv = DW'(secs);
          ddvs = DW'(DAY_S);
        end
        2'd1: begin
          ddiv = drem;
          ddvs = DW'(HOUR_S);
        end
        default: begin
          ddiv = drem;
          ddvs = DW'(MIN_S);
        end
      endcase
    end
  end

  always_comb begin
    case (unit)
      U_DAY: begin
        step_tgt = {1'b0, sday};
        step_cur = {2'b00, dq};
        step_unit = 18'(DAY_S);
      end
      U_HOUR: begin
        step_tgt = {12'd0, shour};
        step_cur = {13'd0, hq};
        step_unit = 18'(HOUR_S);
      end
      U_MIN: begin
        step_tgt = {11'd0, smin};
        step_cur = {12'd0, mq};
        step_unit = 18'(MIN_S);
      end
      default: begin
        step_tgt = {11'd0, ssec};
        step_cur = {12'd0, sq};
        step_unit = 18'd1;
      end
    endcase
    step_diff = step_tgt - step_cur;
  end

  assign g_ext = {5'd0, game_time};
  assign a_ext = {adj[35], adj, 16'd0};
  assign r_pos = g_ext + a_ext;
  assign r_neg = g_ext - a_ext;
  assign r_sel = (unit != U_DAY && r_pos[52]) ? r_neg : r_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (dstart) begin
      div_busy <= 1'b1;
    end else if (ddone) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmpd <= 16'd1440;
      tscale <= 16'd256;
      paused <= 1'b0;
      game_time <= '0;
      state <= S_IDLE;
      phase <= 2'd0;
      obuf_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RMPD:  rmpd <= cfg_data;
          REG_SCALE: tscale <= cfg_data;
          REG_PAUSE: paused <= cfg_data[0];
          default: ;
        endcase
      end
      if (put) begin
        obuf_v <= 1'b1;
      end else if (m_tready) begin
        obuf_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sday <= s_tdata[18:2];
            shour <= s_tdata[24:19];
            smin <= s_tdata[31:25];
            ssec <= s_tdata[38:32];
            unit <= U_DAY;
            phase <= 2'd0;
            if (s_tdata[1:0] == OP_SET) begin
              pend <= {~s_tdata[38], ~s_tdata[31], ~s_tdata[24], ~s_tdata[18]};
              state <= S_NEXT;
            end else begin
              pend <= 4'd0;
              state <= (s_tdata[1:0] == OP_TICK && !paused) ? S_TICK : S_DEC;
            end
          end
        end
        S_TICK: begin
          if (ddone) begin
            game_time <= tick_sum[TW] ? TIME_MAX : tick_sum[TW-1:0];
            state <= S_DEC;
          end
        end
        S_NEXT: begin
          if (pend == 4'd0 || pend[0]) begin
            state <= S_DEC;
          end else begin
            pend <= {1'b0, pend[3:1]};
            unit <= unit + 2'd1;
          end
        end
        S_DEC: begin
          if (ddone) begin
            case (phase)
              2'd0: begin
                dq <= (|dquo[DW-1:16]) ? 16'hFFFF : dquo[15:0];
                phase <= 2'd1;
              end
              2'd1: begin
                hq <= dquo[4:0];
                phase <= 2'd2;
              end
              default: begin
                mq <= dquo[5:0];
                sq <= drem[5:0];
                phase <= 2'd0;
                state <= pend[0] ? S_MUL : S_PUT;
              end
            endcase
          end
        end
        S_MUL: begin
          adj <= step_diff * step_unit;
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (r_sel[52]) begin
            game_time <= '0;
          end else if (|r_sel[51:TW]) begin
            game_time <= TIME_MAX;
          end else begin
            game_time <= r_sel[TW-1:0];
          end
          pend <= {1'b0, pend[3:1]};
          unit <= unit + 2'd1;
          state <= S_NEXT;
        end
        S_PUT: begin
          if (put) begin
            obuf <= {7'd0, secs, sq, mq, hq, dq};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/stod_check.sv =====
// ---------------------------------------------------------------------------
// Scaled time-of-day clock checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module stod_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("busy");
  a_hour: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:16] < 5'd24) else $error("hour");
  a_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26:21] < 6'd60) else $error("minute");
endmodule

bind scaled_time_of_day_clock stod_check u_check (.clk, .rst, .s_tvalid, .s_tready,
  .m_tvalid, .m_tready, .m_tdata);
